FILE: hdl/ptd_pkg.sv
`timescale 1ns / 1ps

package ptd_pkg;

    localparam int FUNC_W       = 3;
    localparam int TASK_ID_W    = 8;
    localparam int PERIOD_W     = 16;
    localparam int SLOT_INDEX_W = 4;
    localparam int STATUS_W     = 2;

    localparam logic [FUNC_W-1:0] FUNC_TICK = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_ADD  = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_SET  = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_PUSH = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_POP  = 3'd4;

    localparam logic [STATUS_W-1:0] ST_DONE   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_REJECT = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD    = 2'd2;

    typedef struct packed {
        logic [FUNC_W-1:0]       func;
        logic [TASK_ID_W-1:0]    task_id;
        logic [PERIOD_W-1:0]     period;
        logic [PERIOD_W-1:0]     start_count;
        logic                    enable;
        logic [SLOT_INDEX_W-1:0] slot_index;
    } ptd_in_t;

    typedef struct packed {
        logic [STATUS_W-1:0]     status;
        logic [SLOT_INDEX_W-1:0] assigned_slot;
        logic [TASK_ID_W-1:0]    ready_task;
        logic                    ready_valid;
    } ptd_out_t;

    typedef struct packed {
        logic capture;
        logic exec;
        logic walk_read;
        logic walk_update;
        logic out_load;
    } ptd_cmd_t;

    typedef struct packed {
        logic walk_start;
        logic walk_done;
        logic out_free;
    } ptd_stat_t;

endpackage

FILE: hdl/ptd_ctrl.sv
`timescale 1ns / 1ps

module ptd_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  ptd_pkg::ptd_stat_t  stat,
    output ptd_pkg::ptd_cmd_t   cmd
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_EXEC   = 2'd1;
    localparam logic [1:0] S_TICK   = 2'd2;
    localparam logic [1:0] S_RESULT = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb begin
        state_next      = state_reg;
        cmd             = '0;
        s_ready         = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_ready     = 1'b1;
                cmd.capture = s_valid;
                if (s_valid) begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                cmd.exec      = 1'b1;
                cmd.walk_read = stat.walk_start;
                state_next    = stat.walk_start ? S_TICK : S_RESULT;
            end
            S_TICK: begin
                cmd.walk_update = 1'b1;
                cmd.walk_read   = !stat.walk_done;
                if (stat.walk_done) begin
                    state_next = S_RESULT;
                end
            end
            S_RESULT: begin
                cmd.out_load = stat.out_free;
                if (stat.out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: hdl/ptd_datapath.sv
`timescale 1ns / 1ps

module ptd_datapath #(
    parameter int SLOT_COUNT  = 16,
    parameter int READY_DEPTH = 16,
    parameter int ID_WIDTH    = 8,
    parameter int COUNT_WIDTH = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  ptd_pkg::ptd_in_t    s_data,
    input  logic                m_ready,
    output logic                m_valid,
    output ptd_pkg::ptd_out_t   m_data,
    input  ptd_pkg::ptd_cmd_t   cmd,
    output ptd_pkg::ptd_stat_t  stat
);

    localparam int SLOT_AW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int SLOT_CW = $clog2(SLOT_COUNT + 1);
    localparam int CMP_W   = (SLOT_CW > ptd_pkg::SLOT_INDEX_W) ? SLOT_CW
                                                                : ptd_pkg::SLOT_INDEX_W;
    localparam int RD_AW   = $clog2(READY_DEPTH);
    localparam int RD_CW   = $clog2(READY_DEPTH + 1);

    logic [ID_WIDTH-1:0]    id_mem   [SLOT_COUNT];
    logic [COUNT_WIDTH-1:0] cnt_mem  [SLOT_COUNT];
    logic [COUNT_WIDTH-1:0] per_mem  [SLOT_COUNT];
    logic [ID_WIDTH-1:0]    fifo_mem [READY_DEPTH];

    ptd_pkg::ptd_in_t   in_reg;
    ptd_pkg::ptd_out_t  m_data_reg;
    logic               m_valid_reg;

    logic [SLOT_CW-1:0]     slots_used_reg, slots_used_next;
    logic [SLOT_CW-1:0]     walk_reg, walk_next;
    logic [SLOT_AW-1:0]     upd_idx_reg;
    logic [RD_AW-1:0]       head_reg, head_next;
    logic [RD_AW-1:0]       tail_reg, tail_next;
    logic [RD_CW-1:0]       count_reg, count_next;
    logic [ptd_pkg::STATUS_W-1:0]     status_reg, status_next;
    logic [ptd_pkg::SLOT_INDEX_W-1:0] slot_reg, slot_next;
    logic                   pop_ok_reg, pop_ok_next;
    logic [ID_WIDTH-1:0]    fifo_rd_reg;
    logic [ID_WIDTH-1:0]    id_rd_reg;
    logic [COUNT_WIDTH-1:0] cnt_rd_reg;
    logic [COUNT_WIDTH-1:0] per_rd_reg;

    logic [ID_WIDTH-1:0]    id_in;
    logic [COUNT_WIDTH-1:0] period_in;
    logic [COUNT_WIDTH-1:0] start_in;
    logic [SLOT_AW-1:0]     add_addr;
    logic [SLOT_AW-1:0]     walk_addr;
    logic                   slots_full;
    logic                   fifo_full;

    logic                   add_we;
    logic                   per_we;
    logic [SLOT_AW-1:0]     per_waddr;
    logic [COUNT_WIDTH-1:0] per_wdata;
    logic                   cnt_we;
    logic [SLOT_AW-1:0]     cnt_waddr;
    logic [COUNT_WIDTH-1:0] cnt_wdata;
    logic                   push_en;
    logic [ID_WIDTH-1:0]    push_data;
    logic                   pop_en;

    assign id_in      = ID_WIDTH'(in_reg.task_id);
    assign period_in  = COUNT_WIDTH'(in_reg.period);
    assign start_in   = COUNT_WIDTH'(in_reg.start_count);
    assign add_addr   = slots_used_reg[SLOT_AW-1:0];
    assign walk_addr  = walk_reg[SLOT_AW-1:0];
    assign slots_full = (slots_used_reg == SLOT_CW'(SLOT_COUNT));
    assign fifo_full  = (count_reg == RD_CW'(READY_DEPTH));

    assign stat.walk_start = (in_reg.func == ptd_pkg::FUNC_TICK) && (slots_used_reg != '0);
    assign stat.walk_done  = (walk_reg == slots_used_reg);
    assign stat.out_free   = !m_valid_reg || m_ready;

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_comb begin
        slots_used_next = slots_used_reg;
        walk_next       = walk_reg;
        status_next     = status_reg;
        slot_next       = slot_reg;
        pop_ok_next     = pop_ok_reg;
        add_we          = 1'b0;
        per_we          = 1'b0;
        per_waddr       = add_addr;
        per_wdata       = period_in;
        cnt_we          = 1'b0;
        cnt_waddr       = add_addr;
        cnt_wdata       = start_in;
        push_en         = 1'b0;
        push_data       = id_in;
        pop_en          = 1'b0;

        if (cmd.capture) begin
            walk_next = '0;
        end

        if (cmd.exec) begin
            status_next = ptd_pkg::ST_DONE;
            slot_next   = '0;
            pop_ok_next = 1'b0;
            unique case (in_reg.func)
                ptd_pkg::FUNC_TICK: begin
                    status_next = ptd_pkg::ST_DONE;
                end
                ptd_pkg::FUNC_ADD: begin
                    if (in_reg.enable && !slots_full) begin
                        add_we          = 1'b1;
                        per_we          = 1'b1;
                        cnt_we          = 1'b1;
                        slot_next       = ptd_pkg::SLOT_INDEX_W'(slots_used_reg);
                        slots_used_next = slots_used_reg + 1'b1;
                    end else begin
                        status_next = ptd_pkg::ST_REJECT;
                    end
                end
                ptd_pkg::FUNC_SET: begin
                    if (CMP_W'(in_reg.slot_index) < CMP_W'(slots_used_reg)) begin
                        per_we    = 1'b1;
                        per_waddr = SLOT_AW'(in_reg.slot_index);
                    end else begin
                        status_next = ptd_pkg::ST_BAD;
                    end
                end
                ptd_pkg::FUNC_PUSH: begin
                    if (!fifo_full) begin
                        push_en = 1'b1;
                    end else begin
                        status_next = ptd_pkg::ST_REJECT;
                    end
                end
                ptd_pkg::FUNC_POP: begin
                    if (count_reg != '0) begin
                        pop_en      = 1'b1;
                        pop_ok_next = 1'b1;
                    end else begin
                        status_next = ptd_pkg::ST_BAD;
                    end
                end
                default: begin
                    status_next = ptd_pkg::ST_REJECT;
                end
            endcase
        end

        if (cmd.walk_read) begin
            walk_next = walk_reg + 1'b1;
        end

        if (cmd.walk_update) begin
            cnt_we    = 1'b1;
            cnt_waddr = upd_idx_reg;
            if (cnt_rd_reg == '0) begin
                cnt_wdata = per_rd_reg;
                push_data = id_rd_reg;
                if (!fifo_full) begin
                    push_en = 1'b1;
                end else begin
                    status_next = ptd_pkg::ST_REJECT;
                end
            end else begin
                cnt_wdata = cnt_rd_reg - 1'b1;
            end
        end
    end

    always_comb begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (push_en) begin
            tail_next  = (tail_reg == RD_AW'(READY_DEPTH - 1)) ? '0 : tail_reg + 1'b1;
            count_next = count_reg + 1'b1;
        end else if (pop_en) begin
            head_next  = (head_reg == RD_AW'(READY_DEPTH - 1)) ? '0 : head_reg + 1'b1;
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (add_we) begin
            id_mem[add_addr] <= id_in;
        end
        if (per_we) begin
            per_mem[per_waddr] <= per_wdata;
        end
        if (cnt_we) begin
            cnt_mem[cnt_waddr] <= cnt_wdata;
        end
        if (cmd.walk_read) begin
            id_rd_reg   <= id_mem[walk_addr];
            cnt_rd_reg  <= cnt_mem[walk_addr];
            per_rd_reg  <= per_mem[walk_addr];
            upd_idx_reg <= walk_addr;
        end
    end

    always_ff @(posedge aclk) begin
        if (push_en) begin
            fifo_mem[tail_reg] <= push_data;
        end
        if (pop_en) begin
            fifo_rd_reg <= fifo_mem[head_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            in_reg <= s_data;
        end
        walk_reg   <= walk_next;
        status_reg <= status_next;
        slot_reg   <= slot_next;
        pop_ok_reg <= pop_ok_next;
        if (cmd.out_load) begin
            m_data_reg.status        <= status_reg;
            m_data_reg.assigned_slot <= slot_reg;
            m_data_reg.ready_task    <= pop_ok_reg ? ptd_pkg::TASK_ID_W'(fifo_rd_reg) : '0;
            m_data_reg.ready_valid   <= pop_ok_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slots_used_reg <= '0;
            head_reg       <= '0;
            tail_reg       <= '0;
            count_reg      <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            slots_used_reg <= slots_used_next;
            head_reg       <= head_next;
            tail_reg       <= tail_next;
            count_reg      <= count_next;
            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

endmodule

FILE: hdl/periodic_task_dispatcher_unit.sv
`timescale 1ns / 1ps
// Periodic task dispatcher: a table of periodic slots feeding a ready FIFO of task ids.
// Input channel s_valid/s_ready/s_data carries one operation word: tick, add slot,
// set slot period, push ready id or pop ready id. Result channel m_valid/m_ready/m_data
// returns exactly one word per operation (status, assigned slot, popped id).
// Sequence: an accepted word is captured and executed in the EXEC state, and its result
// word is then loaded into the output register once that register is free; a tick with
// slots in use first walks them, reading and rewriting one slot per cycle through the slot tables.
// Throughput: one operation at a time; s_ready returns the cycle after the result is
// loaded, so a new word is not taken before the result of the last one is loaded.
// Ticks are expected at a slow timer rate, as a tick walks every slot in use.
// Reset (aresetn low, synchronous) empties the slot table and the ready FIFO and
// drops any pending result word; slot and FIFO storage is not cleared.
// A stalled receiver holds the result word in the output register; the next input
// word is still accepted and worked on, and its result waits until the register
// frees up.

module periodic_task_dispatcher_unit #(
    parameter int SLOT_COUNT  = 16,
    parameter int READY_DEPTH = 16,
    parameter int ID_WIDTH    = 8,
    parameter int COUNT_WIDTH = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  ptd_pkg::ptd_in_t   s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output ptd_pkg::ptd_out_t  m_data
);

    ptd_pkg::ptd_cmd_t  cmd;
    ptd_pkg::ptd_stat_t stat;

    ptd_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    ptd_datapath #(
        .SLOT_COUNT  (SLOT_COUNT),
        .READY_DEPTH (READY_DEPTH),
        .ID_WIDTH    (ID_WIDTH),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .m_ready (m_ready),
        .m_valid (m_valid),
        .m_data  (m_data),
        .cmd     (cmd),
        .stat    (stat)
    );

    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (cmd.exec && !s_ready))
        else $error("accepted word not executed in the next cycle");

    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.walk_update |-> (!s_ready && !cmd.exec && !cmd.out_load))
        else $error("slot walk overlaps another phase");

    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |=> m_valid)
        else $error("result load did not raise m_valid");

    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!m_valid || m_ready))
        else $error("result loaded over an untaken word");

endmodule
